/* design/vts_pkg.sv */
// vts_pkg: shared types and fixed-point constants of the voxel trilinear sampler.
// Depends on nothing; used by design/voxel_trilinear_sampler.sv.
`timescale 1ns / 1ps
`default_nettype none
package vts_pkg;

  // Request opcodes
  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_QUERY = 1'b1
  } op_t;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_CORNER_X  = 3'd0,
    REG_CORNER_Y  = 3'd1,
    REG_CORNER_Z  = 3'd2,
    REG_BASIS_0   = 3'd3,
    REG_BASIS_1   = 3'd4,
    REG_BASIS_2   = 3'd5,
    REG_GRID_DIMS = 3'd6
  } cfg_reg_t;

  localparam int COORD_W    = 32;  // Q16.16 coordinates and corner
  localparam int DIFF_W     = 33;  // point minus corner
  localparam int COEF_W     = 21;  // Q7.14 basis coefficient
  localparam int ROW_W      = 63;  // three packed coefficients
  localparam int PROD_W     = DIFF_W + COEF_W;
  localparam int SUM_W      = PROD_W + 2;
  localparam int INT_LSB    = 30;  // grid coordinate is Q.30
  localparam int FRAC_W     = 16;
  localparam int FRAC_LSB   = INT_LSB - FRAC_W;
  localparam int DIM_W      = 6;
  localparam int DIMS_W     = 3 * DIM_W;
  localparam int ADDR_IN_W  = 15;
  localparam int ADDR_EXT_W = 21;  // covers linear addresses and up to 2^20 voxels
  localparam int CFG_IDX_W  = 3;
  localparam int OUT_W      = 32;

  localparam logic [DIMS_W-1:0] GRID_DIMS_RESET = 18'd133152;

endpackage
`default_nettype wire

/* design/voxel_trilinear_sampler.sv */
// voxel_trilinear_sampler: query/write front pipeline, voxel memory, fetch
// sequencer and lerp pipeline. Depends on design/vts_pkg.sv.
// Throughput: one write per cycle while nothing stalls the fetch slot. An inside query
// holds the fetch slot for the eight reads that share the single voxel memory port, so
// the next query waits for it. Outside queries flow at one per cycle while unstalled.
// Reset clears control state and configuration; voxel memory content is not cleared.
// MAX_VOXELS must be a power of two (unchecked); fetch addresses wrap modulo MAX_VOXELS.
`timescale 1ns / 1ps
`default_nettype none
module voxel_trilinear_sampler #(
  parameter int MAX_VOXELS  = 32768,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 opcode,
  input  logic [vts_pkg::ADDR_IN_W-1:0]        voxel_address,
  input  logic signed [vts_pkg::COORD_W-1:0]   voxel_value,
  input  logic signed [vts_pkg::COORD_W-1:0]   point_x,
  input  logic signed [vts_pkg::COORD_W-1:0]   point_y,
  input  logic signed [vts_pkg::COORD_W-1:0]   point_z,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [vts_pkg::OUT_W-1:0]     sample_value,
  output logic                                 outside_grid,
  input  logic                                 cfg_we,
  input  logic [vts_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [vts_pkg::ROW_W-1:0]            cfg_data
);

  localparam int AW = $clog2(MAX_VOXELS);
  localparam int VW = VALUE_WIDTH;
  localparam int LW = VW + 18;  // (b - a) * fraction
  localparam int DW = vts_pkg::DIFF_W;
  localparam int CW = vts_pkg::COEF_W;
  localparam int PW = vts_pkg::PROD_W;
  localparam int SW = vts_pkg::SUM_W;
  localparam int FW = vts_pkg::FRAC_W;
  localparam int NW = vts_pkg::DIM_W;
  localparam int EW = vts_pkg::ADDR_EXT_W;

  // ---------------------------------------------------------------- config
  logic signed [vts_pkg::COORD_W-1:0] corner [3];
  logic [vts_pkg::ROW_W-1:0]          basis  [3];
  logic [vts_pkg::DIMS_W-1:0]         grid_dims;
  logic [NW-1:0]                      dim [3];
  logic [2*NW-1:0]                    nyz;

  // Take register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int a = 0; a < 3; a++) begin
        corner[a] <= '0;
        basis[a]  <= '0;
      end
      grid_dims <= vts_pkg::GRID_DIMS_RESET;
    end else if (cfg_we) begin
      unique case (vts_pkg::cfg_reg_t'(cfg_index))
        vts_pkg::REG_CORNER_X:  corner[0] <= cfg_data[vts_pkg::COORD_W-1:0];
        vts_pkg::REG_CORNER_Y:  corner[1] <= cfg_data[vts_pkg::COORD_W-1:0];
        vts_pkg::REG_CORNER_Z:  corner[2] <= cfg_data[vts_pkg::COORD_W-1:0];
        vts_pkg::REG_BASIS_0:   basis[0]  <= cfg_data;
        vts_pkg::REG_BASIS_1:   basis[1]  <= cfg_data;
        vts_pkg::REG_BASIS_2:   basis[2]  <= cfg_data;
        vts_pkg::REG_GRID_DIMS: grid_dims <= cfg_data[vts_pkg::DIMS_W-1:0];
        default: ;
      endcase
    end
  end

  assign dim[0] = grid_dims[NW-1:0];
  assign dim[1] = grid_dims[2*NW-1:NW];
  assign dim[2] = grid_dims[3*NW-1:2*NW];
  assign nyz    = dim[1] * dim[2];

  // ---------------------------------------------------------------- stall chain
  logic en1, en2, en3, en4, en5, en_f, en_b1, en_b2, en_b3, en_b4, en_b5, en_o;
  logic fs_done, fs_leave;

  // ---------------------------------------------------------------- stage 1: difference
  logic                 s1_v;
  vts_pkg::op_t         s1_op;
  logic [vts_pkg::ADDR_IN_W-1:0] s1_addr;
  logic signed [vts_pkg::COORD_W-1:0] s1_val;
  logic signed [DW-1:0] s1_diff [3];

  assign in_ready = en1;

  always_ff @(posedge clk) begin
    if (rst) s1_v <= 1'b0;
    else if (en1) s1_v <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_op      <= vts_pkg::op_t'(opcode);
      s1_addr    <= voxel_address;
      s1_val     <= voxel_value;
      s1_diff[0] <= DW'(point_x) - DW'(corner[0]);
      s1_diff[1] <= DW'(point_y) - DW'(corner[1]);
      s1_diff[2] <= DW'(point_z) - DW'(corner[2]);
    end
  end

  // ---------------------------------------------------------------- stage 2: products
  logic                 s2_v;
  vts_pkg::op_t         s2_op;
  logic [vts_pkg::ADDR_IN_W-1:0] s2_addr;
  logic signed [vts_pkg::COORD_W-1:0] s2_val;
  logic signed [PW-1:0] s2_prod [3][3];

  always_ff @(posedge clk) begin
    if (rst) s2_v <= 1'b0;
    else if (en2) s2_v <= s1_v;
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      s2_op   <= s1_op;
      s2_addr <= s1_addr;
      s2_val  <= s1_val;
      for (int a = 0; a < 3; a++) begin
        for (int c = 0; c < 3; c++) begin
          s2_prod[a][c] <= PW'(s1_diff[c]) * PW'($signed(basis[a][CW*c +: CW]));
        end
      end
    end
  end

  // ---------------------------------------------------------------- stage 3: row sums
  logic                 s3_v;
  vts_pkg::op_t         s3_op;
  logic [vts_pkg::ADDR_IN_W-1:0] s3_addr;
  logic signed [vts_pkg::COORD_W-1:0] s3_val;
  logic signed [SW-1:0] s3_sum [3];

  always_ff @(posedge clk) begin
    if (rst) s3_v <= 1'b0;
    else if (en3) s3_v <= s2_v;
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      s3_op   <= s2_op;
      s3_addr <= s2_addr;
      s3_val  <= s2_val;
      for (int a = 0; a < 3; a++) begin
        s3_sum[a] <= SW'(s2_prod[a][0]) + SW'(s2_prod[a][1]) + SW'(s2_prod[a][2]);
      end
    end
  end

  // ---------------------------------------------------------------- stage 4: floor, fraction, bounds
  logic                 s4_v;
  vts_pkg::op_t         s4_op;
  logic [vts_pkg::ADDR_IN_W-1:0] s4_addr;
  logic signed [vts_pkg::COORD_W-1:0] s4_val;
  logic [NW-1:0]        s4_idx [3];
  logic [FW-1:0]        s4_frac [3];
  logic                 s4_out;
  logic [2:0]           axis_out;

  // Flag a cell whose index is negative or whose upper corner reaches the size
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      axis_out[a] = s3_sum[a][SW-1] || (|s3_sum[a][SW-1:vts_pkg::INT_LSB+NW])
                 || ({1'b0, s3_sum[a][vts_pkg::INT_LSB +: NW]} + (NW+1)'(1)
                     >= {1'b0, dim[a]});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) s4_v <= 1'b0;
    else if (en4) s4_v <= s3_v;
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      s4_op   <= s3_op;
      s4_addr <= s3_addr;
      s4_val  <= s3_val;
      s4_out  <= |axis_out;
      for (int a = 0; a < 3; a++) begin
        s4_idx[a]  <= s3_sum[a][vts_pkg::INT_LSB +: NW];
        s4_frac[a] <= s3_sum[a][vts_pkg::FRAC_LSB +: FW];
      end
    end
  end

  // ---------------------------------------------------------------- stage 5: base address
  logic                 s5_v;
  vts_pkg::op_t         s5_op;
  logic [vts_pkg::ADDR_IN_W-1:0] s5_addr;
  logic signed [vts_pkg::COORD_W-1:0] s5_val;
  logic [EW-1:0]        s5_base;
  logic [FW-1:0]        s5_frac [3];
  logic                 s5_out;

  always_ff @(posedge clk) begin
    if (rst) s5_v <= 1'b0;
    else if (en5) s5_v <= s4_v;
  end

  always_ff @(posedge clk) begin
    if (en5) begin
      s5_op   <= s4_op;
      s5_addr <= s4_addr;
      s5_val  <= s4_val;
      s5_out  <= s4_out;
      s5_frac <= s4_frac;
      s5_base <= EW'({{(2*NW){1'b0}}, s4_idx[0]} * {{NW{1'b0}}, nyz})
               + EW'({{NW{1'b0}}, s4_idx[1]} * {{NW{1'b0}}, dim[2]})
               + EW'(s4_idx[2]);
    end
  end

  // ---------------------------------------------------------------- voxel memory
  logic signed [VW-1:0] mem [MAX_VOXELS];
  logic signed [VW-1:0] mem_q;
  logic                 mem_we;
  logic                 rd_issue;
  logic [AW-1:0]        mem_addr;
  logic [EW-1:0]        wr_addr_ext;
  logic [EW-1:0]        rd_addr_ext;
  logic signed [VW-1:0] wr_val;

  logic                 fs_v;
  logic [EW-1:0]        fs_base;
  logic [FW-1:0]        fs_frac [3];
  logic                 fs_out;
  logic [3:0]           rcnt;
  logic                 rd_pend;
  logic [2:0]           rd_sel;
  logic signed [VW-1:0] col [7];

  // In-range writes go to memory as they pass into the fetch slot, after earlier reads
  assign wr_addr_ext = EW'(s5_addr);
  assign wr_val      = VW'(s5_val);
  assign mem_we      = s5_v && en_f && (s5_op == vts_pkg::OP_WRITE)
                    && (wr_addr_ext < EW'(MAX_VOXELS));
  assign rd_issue    = fs_v && !fs_out && !rcnt[3];
  assign rd_addr_ext = fs_base + (rcnt[2] ? EW'(nyz) : '0)
                     + (rcnt[1] ? EW'(dim[2]) : '0) + EW'(rcnt[0]);
  assign mem_addr    = mem_we ? wr_addr_ext[AW-1:0] : rd_addr_ext[AW-1:0];

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= wr_val;
    else if (rd_issue) mem_q <= mem[mem_addr];
  end

  // ---------------------------------------------------------------- fetch sequencer
  assign fs_done  = fs_out || rcnt[3];
  assign fs_leave = fs_v && fs_done && en_b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      fs_v    <= 1'b0;
      rcnt    <= '0;
      rd_pend <= 1'b0;
    end else begin
      rd_pend <= rd_issue;
      if (en_f) begin
        fs_v <= s5_v && (s5_op == vts_pkg::OP_QUERY);
        rcnt <= '0;
      end else if (rd_issue) begin
        rcnt <= rcnt + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_sel <= rcnt[2:0];
    if (en_f) begin
      fs_base <= s5_base;
      fs_frac <= s5_frac;
      fs_out  <= s5_out;
    end
    // Capture returning voxels; the last one stays in the memory output register
    if (rd_pend && (rd_sel != 3'd7)) col[rd_sel] <= mem_q;
  end

  // ---------------------------------------------------------------- lerp helpers
  function automatic logic signed [LW-1:0] lerp_mul(input logic signed [VW-1:0] a,
                                                    input logic signed [VW-1:0] b,
                                                    input logic [FW-1:0] f);
    logic signed [VW:0] d;
    d = (VW+1)'(b) - (VW+1)'(a);
    return LW'(d) * LW'($signed({1'b0, f}));
  endfunction

  function automatic logic signed [VW-1:0] lerp_add(input logic signed [VW-1:0] a,
                                                    input logic signed [LW-1:0] m);
    logic signed [LW-1:0] t;
    t = LW'(a) + (m >>> FW);
    return $signed(t[VW-1:0]);
  endfunction

  logic signed [VW-1:0] vox [8];

  always_comb begin
    for (int i = 0; i < 7; i++) vox[i] = col[i];
    vox[7] = mem_q;
  end

  // ---------------------------------------------------------------- B1/B2: x lerps
  logic                 b1_v, b1_out;
  logic signed [VW-1:0] b1_a [4];
  logic signed [LW-1:0] b1_m [4];
  logic [FW-1:0]        b1_fy, b1_fz;

  always_ff @(posedge clk) begin
    if (rst) b1_v <= 1'b0;
    else if (en_b1) b1_v <= fs_leave;
  end

  always_ff @(posedge clk) begin
    if (en_b1) begin
      b1_out <= fs_out;
      b1_fy  <= fs_frac[1];
      b1_fz  <= fs_frac[2];
      for (int i = 0; i < 4; i++) begin
        b1_a[i] <= vox[i];
        b1_m[i] <= lerp_mul(vox[i], vox[i+4], fs_frac[0]);
      end
    end
  end

  logic                 b2_v, b2_out;
  logic signed [VW-1:0] b2_x [4];
  logic [FW-1:0]        b2_fy, b2_fz;

  always_ff @(posedge clk) begin
    if (rst) b2_v <= 1'b0;
    else if (en_b2) b2_v <= b1_v;
  end

  always_ff @(posedge clk) begin
    if (en_b2) begin
      b2_out <= b1_out;
      b2_fy  <= b1_fy;
      b2_fz  <= b1_fz;
      for (int i = 0; i < 4; i++) b2_x[i] <= lerp_add(b1_a[i], b1_m[i]);
    end
  end

  // ---------------------------------------------------------------- B3/B4: y lerps
  logic                 b3_v, b3_out;
  logic signed [VW-1:0] b3_a [2];
  logic signed [LW-1:0] b3_m [2];
  logic [FW-1:0]        b3_fz;

  always_ff @(posedge clk) begin
    if (rst) b3_v <= 1'b0;
    else if (en_b3) b3_v <= b2_v;
  end

  always_ff @(posedge clk) begin
    if (en_b3) begin
      b3_out  <= b2_out;
      b3_fz   <= b2_fz;
      b3_a[0] <= b2_x[0];
      b3_a[1] <= b2_x[1];
      b3_m[0] <= lerp_mul(b2_x[0], b2_x[2], b2_fy);
      b3_m[1] <= lerp_mul(b2_x[1], b2_x[3], b2_fy);
    end
  end

  logic                 b4_v, b4_out;
  logic signed [VW-1:0] b4_y [2];
  logic [FW-1:0]        b4_fz;

  always_ff @(posedge clk) begin
    if (rst) b4_v <= 1'b0;
    else if (en_b4) b4_v <= b3_v;
  end

  always_ff @(posedge clk) begin
    if (en_b4) begin
      b4_out  <= b3_out;
      b4_fz   <= b3_fz;
      b4_y[0] <= lerp_add(b3_a[0], b3_m[0]);
      b4_y[1] <= lerp_add(b3_a[1], b3_m[1]);
    end
  end

  // ---------------------------------------------------------------- B5/out: z lerp
  logic                 b5_v, b5_out;
  logic signed [VW-1:0] b5_a;
  logic signed [LW-1:0] b5_m;
  logic signed [VW-1:0] z_val;
  logic signed [vts_pkg::OUT_W-1:0] sat_val;

  always_ff @(posedge clk) begin
    if (rst) b5_v <= 1'b0;
    else if (en_b5) b5_v <= b4_v;
  end

  always_ff @(posedge clk) begin
    if (en_b5) begin
      b5_out <= b4_out;
      b5_a   <= b4_y[0];
      b5_m   <= lerp_mul(b4_y[0], b4_y[1], b4_fz);
    end
  end

  assign z_val = lerp_add(b5_a, b5_m);

  // Clamp to the output range when voxels are wider than the result
  generate
    if (VW > vts_pkg::OUT_W) begin : g_sat
      localparam logic signed [VW-1:0] SAT_HI = VW'(64'sh0000_0000_7FFF_FFFF);
      localparam logic signed [VW-1:0] SAT_LO = VW'(-64'sh0000_0000_8000_0000);
      always_comb begin
        priority if (z_val > SAT_HI) sat_val = SAT_HI[vts_pkg::OUT_W-1:0];
        else if (z_val < SAT_LO) sat_val = SAT_LO[vts_pkg::OUT_W-1:0];
        else sat_val = z_val[vts_pkg::OUT_W-1:0];
      end
    end else begin : g_ext
      assign sat_val = vts_pkg::OUT_W'(z_val);
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en_o) out_valid <= b5_v;
  end

  always_ff @(posedge clk) begin
    if (en_o) begin
      outside_grid <= b5_out;
      sample_value <= b5_out ? '0 : sat_val;
    end
  end

  // ---------------------------------------------------------------- advance enables
  assign en_o  = !out_valid || out_ready;
  assign en_b5 = !b5_v || en_o;
  assign en_b4 = !b4_v || en_b5;
  assign en_b3 = !b3_v || en_b4;
  assign en_b2 = !b2_v || en_b3;
  assign en_b1 = !b1_v || en_b2;
  assign en_f  = !fs_v || fs_leave;
  assign en5   = !s5_v || en_f;
  assign en4   = !s4_v || en5;
  assign en3   = !s3_v || en4;
  assign en2   = !s2_v || en3;
  assign en1   = !s1_v || en2;

endmodule
`default_nettype wire
